>>> design/avp_pkg.sv
`timescale 1ns / 1ps

package avp_pkg;

	localparam logic [3:0] V_OK        = 4'd0;
	localparam logic [3:0] V_EMPTY     = 4'd1;
	localparam logic [3:0] V_BACKSLASH = 4'd2;
	localparam logic [3:0] V_ABSOLUTE  = 4'd3;
	localparam logic [3:0] V_DRIVE     = 4'd4;
	localparam logic [3:0] V_EMPTY_SEG = 4'd5;
	localparam logic [3:0] V_DOT_SEG   = 4'd6;
	localparam logic [3:0] V_DOT_END   = 4'd7;
	localparam logic [3:0] V_DEVICE    = 4'd8;
	localparam logic [3:0] V_CONTROL   = 4'd9;
	localparam logic [3:0] V_DEEP      = 4'd10;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] MAX_SEG_RESET = 8'd8;

	// One classified byte of a path.
	typedef struct packed {
		logic       present;
		logic       last;
		logic       slash;
		logic       backslash;
		logic       colon;
		logic       dot;
		logic       space;
		logic       ctrl;
		logic [7:0] upper;
	} avp_rec_t;

endpackage

>>> design/avp_channels.sv
`timescale 1ns / 1ps

interface avp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] path_byte;
	logic       byte_present;
	logic       last_of_path;

	modport source (output valid, output path_byte, output byte_present,
		output last_of_path, input ready);
	modport sink (input valid, input path_byte, input byte_present,
		input last_of_path, output ready);
endinterface

interface avp_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] verdict;
	logic [7:0] segment_total;

	modport source (output valid, output verdict, output segment_total, input ready);
	modport sink (input valid, input verdict, input segment_total, output ready);
endinterface

>>> design/avp_front.sv
`timescale 1ns / 1ps

module avp_front
	import avp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	avp_in_if.sink     path,
	output logic       push_valid,
	input  logic       push_ready,
	output avp_rec_t   push_data
);

	logic     vld_s1;
	avp_rec_t rec_s1;
	avp_rec_t rec;
	logic     keep;

	always_comb begin
		rec.present   = path.byte_present;
		rec.last      = path.last_of_path;
		rec.slash     = path.path_byte == CH_SLASH;
		rec.backslash = path.path_byte == CH_BACKSLASH;
		rec.colon     = path.path_byte == CH_COLON;
		rec.dot       = path.path_byte == CH_DOT;
		rec.space     = path.path_byte == CH_SPACE;
		rec.ctrl      = path.path_byte < CH_SPACE;
		if (path.path_byte >= CH_LOWER_A && path.path_byte <= CH_LOWER_Z) begin
			rec.upper = path.path_byte - CASE_OFFSET;
		end else begin
			rec.upper = path.path_byte;
		end
	end

	// An absent byte that does not end a path carries nothing and is dropped here.
	assign keep       = path.byte_present | path.last_of_path;
	assign path.ready = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_data  = rec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (path.ready) begin
			vld_s1 <= path.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (path.ready && path.valid) begin
			rec_s1 <= rec;
		end
	end

endmodule

>>> design/avp_queue.sv
`timescale 1ns / 1ps

module avp_queue
	import avp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  avp_rec_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output avp_rec_t pop_data
);

	avp_rec_t             mem_q [QDEPTH];
	logic     [QAW-1:0]   wr_ptr_q;
	logic     [QAW-1:0]   rd_ptr_q;
	logic     [QCW-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != QCW'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> design/avp_back.sv
`timescale 1ns / 1ps

module avp_back
	import avp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] max_segments,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  avp_rec_t   pop_data,
	avp_out_if.source  result
);

	typedef struct packed {
		logic [2:0]      len;
		logic            all_dots;
		logic            prev_dot_space;
		logic [3:0][7:0] stem;
		logic [2:0]      stem_len;
		logic            stem_closed;
		logic            ctrl;
	} seg_t;

	typedef struct packed {
		logic [3:0] err;
		logic [8:0] cnt;
	} close_t;

	localparam seg_t SEG_CLEAR = '{len: 3'd0, all_dots: 1'b1, prev_dot_space: 1'b0,
		stem: '0, stem_len: 3'd0, stem_closed: 1'b0, ctrl: 1'b0};

	function automatic logic is_device(input seg_t s);
		logic three;
		logic four;
		three = (s.stem[0] == "C" && s.stem[1] == "O" && s.stem[2] == "N") ||
			(s.stem[0] == "P" && s.stem[1] == "R" && s.stem[2] == "N") ||
			(s.stem[0] == "A" && s.stem[1] == "U" && s.stem[2] == "X") ||
			(s.stem[0] == "N" && s.stem[1] == "U" && s.stem[2] == "L");
		four = ((s.stem[0] == "C" && s.stem[1] == "O" && s.stem[2] == "M") ||
			(s.stem[0] == "L" && s.stem[1] == "P" && s.stem[2] == "T")) &&
			s.stem[3] >= "1" && s.stem[3] <= "9";
		return (s.stem_len == 3'd3 && three) || (s.stem_len == 3'd4 && four);
	endfunction

	function automatic close_t close_seg(input seg_t s, input logic [8:0] cnt,
		input logic [3:0] err, input logic at_end, input logic [7:0] max_seg);
		close_t r;
		r.err = err;
		r.cnt = cnt;
		if (err == V_OK) begin
			if (s.len == 3'd0) begin
				r.err = at_end ? V_OK : V_EMPTY_SEG;
			end else if (s.all_dots && s.len <= 3'd2) begin
				r.err = V_DOT_SEG;
			end else if (s.prev_dot_space) begin
				r.err = V_DOT_END;
			end else if (is_device(s)) begin
				r.err = V_DEVICE;
			end else if (s.ctrl) begin
				r.err = V_CONTROL;
			end else begin
				if (cnt != 9'd511) begin
					r.cnt = cnt + 9'd1;
				end
				if (r.cnt > {1'b0, max_seg}) begin
					r.err = V_DEEP;
				end
			end
		end
		return r;
	endfunction

	logic [1:0] pos_q, pos_n;
	logic       bs_q, bs_n;
	logic       lead_q, lead_n;
	logic       colon_q, colon_n;
	seg_t       seg_q, seg_n;
	logic [8:0] cnt_q, cnt_n;
	logic [3:0] err_q, err_n;
	close_t     mid_close;
	close_t     end_close;
	logic [3:0] verdict_n;
	logic [7:0] total_n;
	logic       take;
	logic       out_vld_q;
	logic [3:0] verdict_q;
	logic [7:0] total_q;

	assign pop_ready = !pop_data.last || !out_vld_q || result.ready;
	assign take      = pop_valid && pop_ready;

	always_comb begin
		pos_n     = pos_q;
		bs_n      = bs_q;
		lead_n    = lead_q;
		colon_n   = colon_q;
		seg_n     = seg_q;
		cnt_n     = cnt_q;
		err_n     = err_q;
		mid_close = close_seg(seg_q, cnt_q, err_q, 1'b0, max_segments);
		if (pop_data.present) begin
			if (pop_data.backslash) begin
				bs_n = 1'b1;
			end
			if (pos_q == 2'd0 && pop_data.slash) begin
				lead_n = 1'b1;
			end
			if (pos_q == 2'd1 && pop_data.colon) begin
				colon_n = 1'b1;
			end
			if (pos_q != 2'd2) begin
				pos_n = pos_q + 2'd1;
			end
			if (pop_data.slash) begin
				cnt_n = mid_close.cnt;
				err_n = mid_close.err;
				seg_n = SEG_CLEAR;
			end else begin
				if (seg_q.len != 3'd5) begin
					seg_n.len = seg_q.len + 3'd1;
				end
				if (!pop_data.dot) begin
					seg_n.all_dots = 1'b0;
				end
				seg_n.prev_dot_space = pop_data.dot || pop_data.space;
				if (pop_data.ctrl) begin
					seg_n.ctrl = 1'b1;
				end
				if (!seg_q.stem_closed) begin
					if (pop_data.dot) begin
						seg_n.stem_closed = 1'b1;
					end else begin
						if (seg_q.stem_len < 3'd4) begin
							seg_n.stem[seg_q.stem_len[1:0]] = pop_data.upper;
						end
						if (seg_q.stem_len != 3'd5) begin
							seg_n.stem_len = seg_q.stem_len + 3'd1;
						end
					end
				end
			end
		end

		end_close = close_seg(seg_n, cnt_n, err_n, 1'b1, max_segments);
		total_n   = 8'd0;
		if (pos_n == 2'd0) begin
			verdict_n = V_EMPTY;
		end else if (bs_n) begin
			verdict_n = V_BACKSLASH;
		end else if (lead_n) begin
			verdict_n = V_ABSOLUTE;
		end else if (colon_n) begin
			verdict_n = V_DRIVE;
		end else begin
			verdict_n = end_close.err;
			total_n   = end_close.cnt[8] ? 8'hFF : end_close.cnt[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			bs_q      <= 1'b0;
			lead_q    <= 1'b0;
			colon_q   <= 1'b0;
			seg_q     <= SEG_CLEAR;
			cnt_q     <= 9'd0;
			err_q     <= V_OK;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				if (pop_data.last) begin
					pos_q   <= 2'd0;
					bs_q    <= 1'b0;
					lead_q  <= 1'b0;
					colon_q <= 1'b0;
					seg_q   <= SEG_CLEAR;
					cnt_q   <= 9'd0;
					err_q   <= V_OK;
				end else begin
					pos_q   <= pos_n;
					bs_q    <= bs_n;
					lead_q  <= lead_n;
					colon_q <= colon_n;
					seg_q   <= seg_n;
					cnt_q   <= cnt_n;
					err_q   <= err_n;
				end
			end
			if (take && pop_data.last) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_data.last) begin
			verdict_q <= verdict_n;
			total_q   <= total_n;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.verdict       = verdict_q;
	assign result.segment_total = total_q;

endmodule

>>> design/archive_path_validator.sv
`timescale 1ns / 1ps
// Accepts one path byte per cycle while path.ready is high; an item passes the front stage
// register, the four-entry queue and the back state update, so sustained throughput is one
// item per cycle unless the queue fills; the verdict is registered when the back takes the last item.
// Reset is asynchronous and active low; it clears all path state and queue pointers and
// sets max_segments to 8.

module archive_path_validator
	import avp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	avp_in_if.sink      path,
	avp_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] max_seg_q;
	logic       push_valid;
	logic       push_ready;
	avp_rec_t   push_data;
	logic       pop_valid;
	logic       pop_ready;
	avp_rec_t   pop_data;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, max_seg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seg_q <= MAX_SEG_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			max_seg_q <= pwdata[7:0];
		end
	end

	avp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.path       (path),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	avp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	avp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_segments (max_seg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result       (result)
	);

endmodule
